// ----- hw/rtl/aes_pkg.sv -----
`timescale 1ns / 1ps

package aes_pkg;

  // field widths
  localparam int unsigned LevelW  = 8;
  localparam int unsigned SpeedW  = 8;
  localparam int unsigned ExpW    = 16;
  localparam int unsigned GainW   = 10;
  localparam int unsigned StepW   = LevelW + SpeedW;
  localparam int unsigned DeltaGW = 13;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 32;

  // reset values of registers and state
  localparam logic [LevelW-1:0] TargetReset   = 8'd128;
  localparam logic [SpeedW-1:0] SpeedDefault  = 8'd5;
  localparam logic [ExpW-1:0]   ExpFloorReset = 16'd0;
  localparam logic [ExpW-1:0]   ExpCeilReset  = 16'hFFFF;
  localparam logic [GainW-1:0]  GainFloorReset = 10'd0;
  localparam logic [GainW-1:0]  GainCeilReset  = 10'h3FF;
  localparam logic [ExpW-1:0]   ExpStart      = 16'd1000;
  localparam logic [GainW-1:0]  GainStart     = 10'h080;

  // reciprocal of ten, exact for every 16-bit dividend
  localparam logic [16:0] RecipTen   = 17'd52429;
  localparam int unsigned RecipShift = 19;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET     = 3'd0,
    REG_SPEED      = 3'd1,
    REG_EXP_FLOOR  = 3'd2,
    REG_EXP_CEIL   = 3'd3,
    REG_GAIN_FLOOR = 3'd4,
    REG_GAIN_CEIL  = 3'd5
  } aes_reg_e;

  // direction of the correction
  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } aes_dir_e;

  // limits seen by the update logic
  typedef struct packed {
    logic [ExpW-1:0]  exp_floor;
    logic [ExpW-1:0]  exp_ceil;
    logic [GainW-1:0] gain_floor;
    logic [GainW-1:0] gain_ceil;
  } aes_lim_t;

  // one registered step request
  typedef struct packed {
    aes_dir_e         dir;
    logic [StepW-1:0] step;
  } aes_req_t;

endpackage

// ----- hw/rtl/aes_update.sv -----
`timescale 1ns / 1ps

module aes_update import aes_pkg::*; (
  input  aes_lim_t         lim_i,
  input  aes_req_t         req_i,
  input  logic [ExpW-1:0]  cur_exp_i,
  input  logic [GainW-1:0] cur_gain_i,
  output logic [ExpW-1:0]  new_exp_o,
  output logic [GainW-1:0] new_gain_o
);

  logic [StepW+16:0]   prod;
  logic [DeltaGW-1:0]  dgain;
  logic [ExpW:0]       exp_sum;
  logic [DeltaGW:0]    gain_sum;
  logic [GainW-1:0]    gain_gap;
  logic [ExpW-1:0]     exp_gap;
  logic [ExpW-1:0]     exp_mid;
  logic [GainW-1:0]    gain_mid;

  // gain step is step / 10 by reciprocal multiply
  assign prod  = {1'b0, req_i.step} * {{StepW{1'b0}}, RecipTen};
  assign dgain = prod[RecipShift +: DeltaGW];

  // proportional step
  always_comb begin
    exp_mid  = cur_exp_i;
    gain_mid = cur_gain_i;
    exp_sum  = {1'b0, cur_exp_i} + {1'b0, req_i.step};
    gain_sum = {{(DeltaGW+1-GainW){1'b0}}, cur_gain_i} + {1'b0, dgain};
    gain_gap = cur_gain_i - lim_i.gain_floor;
    exp_gap  = cur_exp_i - lim_i.exp_floor;
    case (req_i.dir)
      DIR_UP: begin
        if (exp_sum > {1'b0, lim_i.exp_ceil}) begin
          exp_mid = lim_i.exp_ceil;
          if (gain_sum > {{(DeltaGW+1-GainW){1'b0}}, lim_i.gain_ceil}) begin
            gain_mid = lim_i.gain_ceil;
          end else begin
            gain_mid = gain_sum[GainW-1:0];
          end
        end else begin
          exp_mid = exp_sum[ExpW-1:0];
        end
      end
      DIR_DOWN: begin
        // gain gives way first
        if (cur_gain_i > lim_i.gain_floor) begin
          if (dgain > {{(DeltaGW-GainW){1'b0}}, gain_gap}) begin
            gain_mid = lim_i.gain_floor;
          end else begin
            gain_mid = cur_gain_i - dgain[GainW-1:0];
          end
        end
        // exposure falls once gain is at its floor
        if ((gain_mid <= lim_i.gain_floor) && (cur_exp_i > lim_i.exp_floor)) begin
          if (req_i.step > exp_gap) begin
            exp_mid = lim_i.exp_floor;
          end else begin
            exp_mid = cur_exp_i - req_i.step;
          end
        end
      end
      default: begin
        exp_mid  = cur_exp_i;
        gain_mid = cur_gain_i;
      end
    endcase
  end

  // final clamp, ceiling applied last
  always_comb begin
    new_exp_o = exp_mid;
    if (new_exp_o < lim_i.exp_floor) new_exp_o = lim_i.exp_floor;
    if (new_exp_o > lim_i.exp_ceil) new_exp_o = lim_i.exp_ceil;
    new_gain_o = gain_mid;
    if (new_gain_o < lim_i.gain_floor) new_gain_o = lim_i.gain_floor;
    if (new_gain_o > lim_i.gain_ceil) new_gain_o = lim_i.gain_ceil;
  end

endmodule

// ----- hw/rtl/auto_exposure_step_core.sv -----
`timescale 1ns / 1ps

// channel    direction  transaction carries
// s_axis     in         tdata[7:0] measured_level
// m_axis     out        tdata[15:0] new_exposure, tdata[25:16] new_analog_gain
// cfg        in         cfg_index_i register index, cfg_data_i write data
//
// one item per cycle sustained while m_axis is ready; a transaction is held in the input stage, then in the result
// the 8x8 step product is registered on input, the update logic sits between
// that register and the exposure/gain register, which is also the result
// reset: exposure 1000, gain 128, registers at their defaults, nothing pending
// a stalled result holds the input stage; the config port is always ready

module auto_exposure_step_core import aes_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InTdataW-1:0]  s_axis_tdata_i,   // [7:0] measured_level
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o,   // [15:0] new_exposure, [25:16] new_analog_gain
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDatW-1:0]   cfg_data_i
);

  logic [LevelW-1:0] target_q;
  logic [SpeedW-1:0] speed_q;
  aes_lim_t          lim_q;
  aes_req_t          req_q, req_d;
  logic              in_vld_q;
  logic              out_vld_q;
  logic [ExpW-1:0]   exp_q, exp_d;
  logic [GainW-1:0]  gain_q, gain_d;
  logic [SpeedW-1:0] speed_eff;
  logic [LevelW-1:0] err_mag;
  logic              in_fire;
  logic              advance;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q         <= TargetReset;
      speed_q          <= SpeedDefault;
      lim_q.exp_floor  <= ExpFloorReset;
      lim_q.exp_ceil   <= ExpCeilReset;
      lim_q.gain_floor <= GainFloorReset;
      lim_q.gain_ceil  <= GainCeilReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TARGET:     target_q         <= cfg_data_i[LevelW-1:0];
        REG_SPEED:      speed_q          <= cfg_data_i[SpeedW-1:0];
        REG_EXP_FLOOR:  lim_q.exp_floor  <= cfg_data_i[ExpW-1:0];
        REG_EXP_CEIL:   lim_q.exp_ceil   <= cfg_data_i[ExpW-1:0];
        REG_GAIN_FLOOR: lim_q.gain_floor <= cfg_data_i[GainW-1:0];
        REG_GAIN_CEIL:  lim_q.gain_ceil  <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // handshake between the two stages
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // error magnitude, direction and step product
  always_comb begin
    speed_eff = (speed_q == '0) ? SpeedDefault : speed_q;
    if (target_q > s_axis_tdata_i[LevelW-1:0]) begin
      req_d.dir = DIR_UP;
      err_mag   = target_q - s_axis_tdata_i[LevelW-1:0];
    end else if (target_q < s_axis_tdata_i[LevelW-1:0]) begin
      req_d.dir = DIR_DOWN;
      err_mag   = s_axis_tdata_i[LevelW-1:0] - target_q;
    end else begin
      req_d.dir = DIR_HOLD;
      err_mag   = '0;
    end
    req_d.step = {{SpeedW{1'b0}}, err_mag} * {{LevelW{1'b0}}, speed_eff};
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_d;
    end
  end

  // update logic
  aes_update u_update (
    .lim_i      (lim_q),
    .req_i      (req_q),
    .cur_exp_i  (exp_q),
    .cur_gain_i (gain_q),
    .new_exp_o  (exp_d),
    .new_gain_o (gain_d)
  );

  // exposure and gain state, doubling as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      exp_q     <= ExpStart;
      gain_q    <= GainStart;
    end else begin
      if (advance) begin
        out_vld_q <= 1'b1;
        exp_q     <= exp_d;
        gain_q    <= gain_d;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutTdataW-GainW-ExpW){1'b0}}, gain_q, exp_q};

  // checks
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_vld_q)
    else $error("accepted transaction not held in input stage");

  a_advance_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid_o)
    else $error("update did not present a result");

  a_exp_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (exp_q <= $past(lim_q.exp_ceil)))
    else $error("exposure above ceiling after update");

  a_gain_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (gain_q <= $past(lim_q.gain_ceil)))
    else $error("gain above ceiling after update");

endmodule
